/* rtl/whirlpool_compression_macros.svh */
// Assertion macros for the Whirlpool compression block.
`ifndef WHIRLPOOL_COMPRESSION_MACROS_SVH
`define WHIRLPOOL_COMPRESSION_MACROS_SVH
`ifndef SYNTHESIS
`define WPC_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WPC_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error(msg);
`else
`define WPC_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define WPC_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg)
`endif
`endif

/* rtl/wpc_pkg.sv */
// ----------------------------------------------------------------------------
// wpc_pkg
// Types, constants and round functions shared by the Whirlpool block.
// ----------------------------------------------------------------------------
package wpc_pkg;
    localparam int RoundCount = 10;
    localparam int RndW = $clog2(RoundCount);
    typedef logic [63:0] t_row;
    typedef t_row [7:0] t_state;
    typedef struct packed {
        t_state msg;
        logic   start;
        logic   last;
    } t_job;

    localparam logic [3:0] EBOX [16] = '{4'd1, 4'd11, 4'd9, 4'd12, 4'd13, 4'd6,
        4'd15, 4'd3, 4'd14, 4'd8, 4'd7, 4'd4, 4'd10, 4'd2, 4'd5, 4'd0};
    localparam logic [3:0] EIBOX [16] = '{4'd15, 4'd0, 4'd13, 4'd7, 4'd11, 4'd14,
        4'd5, 4'd10, 4'd9, 4'd2, 4'd12, 4'd1, 4'd3, 4'd4, 4'd8, 4'd6};
    localparam logic [3:0] RBOX [16] = '{4'd7, 4'd12, 4'd11, 4'd13, 4'd14, 4'd4,
        4'd9, 4'd15, 4'd6, 4'd3, 4'd8, 4'd10, 4'd2, 4'd5, 4'd1, 4'd0};
    localparam logic [7:0] GfPoly = 8'h1D;
    localparam logic [3:0] MDS [8] = '{4'd1, 4'd1, 4'd4, 4'd1, 4'd8, 4'd5, 4'd2, 4'd9};

    function automatic logic [7:0] sbox(input logic [7:0] u);
        logic [3:0] l, r, t;
        l = EBOX[u[7:4]];
        r = EIBOX[u[3:0]];
        t = RBOX[l ^ r];
        return {EBOX[l ^ t], EIBOX[r ^ t]};
    endfunction

    function automatic logic [7:0] gf_dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? GfPoly : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [3:0] c);
        logic [7:0] acc, p;
        acc = '0;
        p = a;
        for (int b = 0; b < 4; b++) begin
            if (c[b]) acc = acc ^ p;
            p = gf_dbl(p);
        end
        return acc;
    endfunction

    function automatic t_state wround(input t_state x);
        logic [7:0] a [8][8];
        logic [7:0] s [8][8];
        logic [7:0] acc;
        t_state o;
        for (int i = 0; i < 8; i++)
            for (int j = 0; j < 8; j++)
                a[i][j] = sbox(x[i][63-8*j -: 8]);
        for (int i = 0; i < 8; i++)
            for (int j = 0; j < 8; j++)
                s[i][j] = a[(i - j + 8) % 8][j];
        for (int i = 0; i < 8; i++)
            for (int j = 0; j < 8; j++) begin
                acc = '0;
                for (int d = 0; d < 8; d++)
                    acc = acc ^ gf_mul(s[i][(j - d + 8) % 8], MDS[d]);
                o[i][63-8*j -: 8] = acc;
            end
        return o;
    endfunction

    function automatic t_row rconst(input logic [RndW-1:0] r);
        t_row v;
        for (int j = 0; j < 8; j++)
            v[63-8*j -: 8] = sbox(8'({r, 3'(j)}));
        return v;
    endfunction
endpackage

/* rtl/whirlpool_compression.sv */
// ----------------------------------------------------------------------------
// whirlpool_compression
// Whirlpool 512-bit compression with Miyaguchi-Preneel chaining.
// ----------------------------------------------------------------------------
// One item on the input channel is one 64-byte message block, as eight
// big-endian rows, with start_req and last_block flags. An item is accepted
// when i_valid is high and o_stall is low. Start clears the chaining value
// before the block; last makes the chaining value after the block appear on
// the output channel, taken when o_valid is high and i_stall is low.
// A two-entry queue decouples the input from the round engine. The engine
// computes one key-schedule round and one data round per cycle, so a block
// is first loaded from the queue and then runs through all its rounds; the
// engine loads no new block until it has finished the current one. The
// o_valid register is set as the final round of a last block completes.
// A held result blocks the engine from loading the next block until taken,
// while the queue still accepts up to two items.
// Reset clears the chaining value to zero and empties the queue.
// ----------------------------------------------------------------------------
`include "whirlpool_compression_macros.svh"
module whirlpool_compression (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_row0,
    input  logic [63:0] i_row1,
    input  logic [63:0] i_row2,
    input  logic [63:0] i_row3,
    input  logic [63:0] i_row4,
    input  logic [63:0] i_row5,
    input  logic [63:0] i_row6,
    input  logic [63:0] i_row7,
    input  logic        i_start_req,
    input  logic        i_last_block,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_hash0,
    output logic [63:0] o_hash1,
    output logic [63:0] o_hash2,
    output logic [63:0] o_hash3,
    output logic [63:0] o_hash4,
    output logic [63:0] o_hash5,
    output logic [63:0] o_hash6,
    output logic [63:0] o_hash7
);
    import wpc_pkg::*;
    t_job in_job, q_job;
    t_state hash;
    logic q_valid, q_take, busy;

    // Row 0 of the block sits in element 0 of the state.
    assign in_job.msg = {i_row7, i_row6, i_row5, i_row4, i_row3, i_row2, i_row1, i_row0};
    assign in_job.start = i_start_req;
    assign in_job.last = i_last_block;

    wpc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_job(in_job), .o_valid(q_valid), .i_take(q_take), .o_job(q_job)
    );

    wpc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .o_take(q_take),
        .i_job(q_job), .o_valid(o_valid), .i_stall(i_stall), .o_hash(hash),
        .o_busy(busy)
    );

    assign o_hash0 = hash[0];
    assign o_hash1 = hash[1];
    assign o_hash2 = hash[2];
    assign o_hash3 = hash[3];
    assign o_hash4 = hash[4];
    assign o_hash5 = hash[5];
    assign o_hash6 = hash[6];
    assign o_hash7 = hash[7];

    // A held result must not change while the receiver stalls.
    `WPC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, $stable(o_hash0), "result changed under stall")
    // The engine never loads a block while it is running one.
    `WPC_ASSERT_IMPL(a_noload, i_clk, i_rst_n, busy |-> !q_take, "load while busy")
    // A full queue stalls the input.
    `WPC_ASSERT_NEXT(a_full, i_clk, i_rst_n, o_stall && !q_take, o_stall, "queue stall dropped")
endmodule

/* rtl/wpc_front.sv */
// ----------------------------------------------------------------------------
// wpc_front
// Accepts items and holds them in a two-entry queue for the round engine.
// ----------------------------------------------------------------------------
module wpc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  wpc_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_take,
    output wpc_pkg::t_job o_job
);
    import wpc_pkg::*;
    t_job r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_stall = (r_cnt == 2'd2);
    assign push = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign pop = o_valid && i_take;
    assign o_job = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_job;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

/* rtl/wpc_back.sv */
// ----------------------------------------------------------------------------
// wpc_back
// Round engine: one key and one data round per cycle, then the update.
// ----------------------------------------------------------------------------
module wpc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_take,
    input  wpc_pkg::t_job    i_job,
    output logic             o_valid,
    input  logic             i_stall,
    output wpc_pkg::t_state  o_hash,
    output logic             o_busy
);
    import wpc_pkg::*;
    t_state r_h, r_k, r_b, r_m, r_out;
    t_state k_nx, b_rnd, b_nx, n_h;
    logic [RndW-1:0] r_rnd;
    logic r_busy, r_last, r_ov;
    logic done;

    assign o_busy = r_busy;
    assign o_take = !r_busy && !(r_ov && i_stall);
    assign o_valid = r_ov;
    assign o_hash = r_out;
    assign done = r_busy && (r_rnd == RndW'(RoundCount - 1));

    always_comb begin
        k_nx = wround(r_k);
        k_nx[0] = k_nx[0] ^ rconst(r_rnd);
        b_rnd = wround(r_b);
        b_nx = b_rnd ^ k_nx;
        n_h = r_h ^ r_m ^ b_nx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov <= 1'b0;
            r_rnd <= '0;
            r_h <= '0;
        end else begin
            if (r_ov && !i_stall) r_ov <= 1'b0;
            if (i_valid && o_take) begin
                r_busy <= 1'b1;
                r_rnd <= '0;
                r_m <= i_job.msg;
                r_last <= i_job.last;
                for (int i = 0; i < 8; i++) begin
                    r_k[i] <= i_job.start ? '0 : r_h[i];
                    r_b[i] <= i_job.msg[i] ^ (i_job.start ? '0 : r_h[i]);
                end
                if (i_job.start) r_h <= '0;
            end else if (r_busy) begin
                r_k <= k_nx;
                r_b <= b_nx;
                r_rnd <= r_rnd + 1'b1;
                if (done) begin
                    r_busy <= 1'b0;
                    r_h <= n_h;
                    if (r_last) begin
                        r_ov <= 1'b1;
                        r_out <= n_h;
                    end
                end
            end
        end
    end
endmodule
